>>> design/pmfb_pkg.sv
// Shared types, sizes and coefficient tables for the polyphase mixer and FIR bank.
// Used by polyphase_mix_fir_bank_core; depends on nothing else.
package pmfb_pkg;

   // Block sizes.
   localparam int CHANNELS    = 16;
   localparam int TAPS        = 10;
   localparam int PHASES      = 4;
   localparam int SAMPLE_BITS = 16;

   // Size of the coefficient tables; channels and taps beyond them wrap or read zero.
   localparam int TBL_CH   = 16;
   localparam int TBL_TAPS = 10;
   localparam int TBL_CH_W = 4;

   // Derived widths.
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TW_W       = 6;                  // twiddle parts, at most 31 in magnitude
   localparam int COEF_W     = 10;                 // FIR coefficients, -85 to 511
   localparam int PROD_W     = SAMPLE_BITS + 5;    // sample times twiddle part
   localparam int MUL_W      = PROD_W + COEF_W;    // delay entry times FIR coefficient
   localparam int ACC_W      = 32;
   localparam int CH_OUT_W   = 4;
   localparam int GROUP_SIZE = 4;
   localparam int GROUPS     = (TAPS + GROUP_SIZE - 1) / GROUP_SIZE;

   // Stream payload widths.
   localparam int REQ_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = CH_OUT_W + 2 * ACC_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Output queue.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;

   typedef logic signed [PROD_W-1:0] tap_type;
   typedef logic signed [TW_W-1:0]   twiddle_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // One channel's delay line, newest entry at index 0.
   typedef struct packed {
      logic [TAPS-1:0][PROD_W-1:0] re;
      logic [TAPS-1:0][PROD_W-1:0] im;
   } row_type;

   // Mixer rotation, a quarter turn clockwise per frame.
   typedef enum logic [1:0] {
      PH_0   = 2'd0,
      PH_90  = 2'd1,
      PH_180 = 2'd2,
      PH_270 = 2'd3
   } phase_type;

   // One finished result.
   typedef struct packed {
      logic               last;
      acc_type            im;
      acc_type            re;
      logic [CH_OUT_W-1:0] ch;
   } result_type;

   localparam twiddle_type TWIDDLE_RE [TBL_CH] = '{
      6'sd31, 6'sd31, 6'sd31, 6'sd30, 6'sd29, 6'sd28, 6'sd26, 6'sd24,
      6'sd22, 6'sd20, 6'sd17, 6'sd15, 6'sd12, 6'sd9,  6'sd6,  6'sd3 };

   localparam twiddle_type TWIDDLE_IM [TBL_CH] = '{
      6'sd0,  6'sd3,  6'sd6,  6'sd9,  6'sd12, 6'sd15, 6'sd17, 6'sd20,
      6'sd22, 6'sd24, 6'sd26, 6'sd28, 6'sd29, 6'sd30, 6'sd31, 6'sd31 };

   localparam coef_type FIR_TABLE [TBL_CH][TBL_TAPS] = '{
      '{ -10'sd5,  10'sd21,  10'sd3,  -10'sd84, 10'sd200, 10'sd511, 10'sd170, -10'sd85,
          10'sd8,  10'sd19 },
      '{  10'sd0,  10'sd23, -10'sd3,  -10'sd82, 10'sd230, 10'sd507, 10'sd141, -10'sd85,
          10'sd13, 10'sd17 },
      '{  10'sd1,  10'sd25, -10'sd10, -10'sd77, 10'sd260, 10'sd500, 10'sd113, -10'sd82,
          10'sd17, 10'sd15 },
      '{  10'sd1,  10'sd26, -10'sd17, -10'sd70, 10'sd289, 10'sd491, 10'sd86,  -10'sd79,
          10'sd21, 10'sd13 },
      '{  10'sd2,  10'sd27, -10'sd24, -10'sd62, 10'sd318, 10'sd478, 10'sd61,  -10'sd74,
          10'sd24, 10'sd11 },
      '{  10'sd2,  10'sd28, -10'sd32, -10'sd50, 10'sd347, 10'sd462, 10'sd37,  -10'sd68,
          10'sd26, 10'sd9 },
      '{  10'sd3,  10'sd29, -10'sd40, -10'sd37, 10'sd373, 10'sd443, 10'sd16,  -10'sd62,
          10'sd28, 10'sd8 },
      '{  10'sd5,  10'sd29, -10'sd47, -10'sd22, 10'sd399, 10'sd422, -10'sd4,  -10'sd55,
          10'sd29, 10'sd6 },
      '{  10'sd6,  10'sd29, -10'sd55, -10'sd4,  10'sd422, 10'sd399, -10'sd22, -10'sd47,
          10'sd29, 10'sd5 },
      '{  10'sd8,  10'sd28, -10'sd62,  10'sd16, 10'sd443, 10'sd373, -10'sd37, -10'sd40,
          10'sd29, 10'sd3 },
      '{  10'sd9,  10'sd26, -10'sd68,  10'sd37, 10'sd462, 10'sd347, -10'sd50, -10'sd32,
          10'sd28, 10'sd2 },
      '{  10'sd11, 10'sd24, -10'sd74,  10'sd61, 10'sd478, 10'sd318, -10'sd62, -10'sd24,
          10'sd27, 10'sd2 },
      '{  10'sd13, 10'sd21, -10'sd79,  10'sd86, 10'sd491, 10'sd289, -10'sd70, -10'sd17,
          10'sd26, 10'sd1 },
      '{  10'sd15, 10'sd17, -10'sd82,  10'sd113, 10'sd500, 10'sd260, -10'sd77, -10'sd10,
          10'sd25, 10'sd1 },
      '{  10'sd17, 10'sd13, -10'sd85,  10'sd141, 10'sd507, 10'sd230, -10'sd82, -10'sd3,
          10'sd23, 10'sd0 },
      '{  10'sd19, 10'sd8,  -10'sd85,  10'sd170, 10'sd511, 10'sd200, -10'sd84, 10'sd3,
          10'sd21, -10'sd5 } };

   // FIR coefficient of a table column and tap; taps past the table are zero.
   function automatic coef_type tap_coef(input logic [TBL_CH_W-1:0] col, input int k);
      coef_type c;
      c = '0;
      if (k < TBL_TAPS) begin
         c = FIR_TABLE[col][k];
      end
      return c;
   endfunction

endpackage

>>> design/polyphase_mix_fir_bank_core.sv
// Polyphase mixer and FIR bank, one real sample per request, channels in turn.
// Uses pmfb_pkg for sizes, the coefficient tables and the row and result types.
// A request passes the stage 1, 2 and 3 registers before its result enters the queue;
// the receiver can take the result from the queue once it has been written.
// Throughput: one request per cycle while the queue has room, set by one read-modify-write
// of a channel's delay-line row per request (read on acceptance, written in the next cycle).
// Reset: synchronous, clears the channel and phase counters, the per-row valid bits
// (a row not yet written reads as an all-zero delay line), the pipeline and the queue.
// The block accepts requests in the first cycle after reset; no clearing pass is needed.
module polyphase_mix_fir_bank_core (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel; tdata: sample.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pmfb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Result channel; tdata: channel, out_real, out_imag, zero fill. tlast: frame_last.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pmfb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   // Request acceptance and mixer.
   logic                                   req_fire;
   logic [pmfb_pkg::CH_W-1:0]              ch_ff, ch_in;
   pmfb_pkg::phase_type                    phase_ff, phase_in;
   logic                                   ch_last;
   logic [6:0]                             ch_wide;
   logic [pmfb_pkg::TBL_CH_W-1:0]          acc_col;
   logic signed [pmfb_pkg::SAMPLE_BITS-1:0] sample_s;
   pmfb_pkg::twiddle_type                  tw_re, tw_im, mix_re, mix_im;
   logic signed [pmfb_pkg::SAMPLE_BITS+pmfb_pkg::TW_W-1:0] mix_prod_re, mix_prod_im;

   // Delay-line memory, one row per channel.
   pmfb_pkg::row_type                      delay_mem [pmfb_pkg::CHANNELS];
   logic [pmfb_pkg::CHANNELS-1:0]          row_valid_ff;
   pmfb_pkg::row_type                      rd_row_ff;
   logic                                   rd_ok_ff;

   // Stage 1: read data back, shift in the new tap, multiply by the FIR taps.
   logic                                   s1_valid_ff;
   logic [pmfb_pkg::CH_W-1:0]              s1_ch_ff;
   logic                                   s1_last_ff;
   pmfb_pkg::tap_type                      s1_new_re_ff, s1_new_im_ff;
   pmfb_pkg::row_type                      old_row, new_row;
   logic [6:0]                             s1_ch_wide;
   logic signed [pmfb_pkg::MUL_W-1:0]      mul_re_in [pmfb_pkg::TAPS];
   logic signed [pmfb_pkg::MUL_W-1:0]      mul_im_in [pmfb_pkg::TAPS];

   // Stage 2: products, summed in groups.
   logic                                   s2_valid_ff;
   logic [pmfb_pkg::CH_W-1:0]              s2_ch_ff;
   logic                                   s2_last_ff;
   logic signed [pmfb_pkg::MUL_W-1:0]      mul_re_ff [pmfb_pkg::TAPS];
   logic signed [pmfb_pkg::MUL_W-1:0]      mul_im_ff [pmfb_pkg::TAPS];
   pmfb_pkg::acc_type                      grp_re_in [pmfb_pkg::GROUPS];
   pmfb_pkg::acc_type                      grp_im_in [pmfb_pkg::GROUPS];

   // Stage 3: group sums, summed to the result.
   logic                                   s3_valid_ff;
   logic [pmfb_pkg::CH_W-1:0]              s3_ch_ff;
   logic                                   s3_last_ff;
   pmfb_pkg::acc_type                      grp_re_ff [pmfb_pkg::GROUPS];
   pmfb_pkg::acc_type                      grp_im_ff [pmfb_pkg::GROUPS];
   pmfb_pkg::result_type                   push_data;
   logic [6:0]                             s3_ch_wide;

   // Output queue.
   pmfb_pkg::result_type                   fifo_mem_ff [pmfb_pkg::FIFO_DEPTH];
   logic [pmfb_pkg::FIFO_AW-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [pmfb_pkg::FIFO_AW:0]             count_ff, count_in;
   logic [pmfb_pkg::FIFO_AW:0]             occupancy;
   logic                                   fifo_push, fifo_pop;
   pmfb_pkg::result_type                   head;

   // Room is reserved for every request still in the pipeline, so the stages never stall.
   assign occupancy  = count_ff + (pmfb_pkg::FIFO_AW+1)'(s1_valid_ff)
                     + (pmfb_pkg::FIFO_AW+1)'(s2_valid_ff)
                     + (pmfb_pkg::FIFO_AW+1)'(s3_valid_ff);
   assign req_tready = !reset
                     && (occupancy < (pmfb_pkg::FIFO_AW+1)'(pmfb_pkg::FIFO_DEPTH));
   assign req_fire   = req_tvalid && req_tready;

   // Channel and phase counters.
   assign ch_last = (ch_ff == pmfb_pkg::CH_W'(pmfb_pkg::CHANNELS - 1));

   always_comb begin
      ch_in    = ch_ff;
      phase_in = phase_ff;
      if (req_fire) begin
         if (ch_last) begin
            ch_in    = '0;
            phase_in = pmfb_pkg::phase_type'(phase_ff + 2'd1);
         end else begin
            ch_in = ch_ff + pmfb_pkg::CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff    <= '0;
         phase_ff <= pmfb_pkg::PH_0;
      end else begin
         ch_ff    <= ch_in;
         phase_ff <= phase_in;
      end
   end

   // Mixer: the channel's twiddle, rotated by the phase, times the sample.
   assign ch_wide  = 7'(ch_ff);
   assign acc_col  = ch_wide[pmfb_pkg::TBL_CH_W-1:0];
   assign sample_s = req_tdata[pmfb_pkg::SAMPLE_BITS-1:0];
   assign tw_re    = pmfb_pkg::TWIDDLE_RE[acc_col];
   assign tw_im    = pmfb_pkg::TWIDDLE_IM[acc_col];

   always_comb begin
      case (phase_ff)
         pmfb_pkg::PH_0: begin
            mix_re = tw_re;
            mix_im = tw_im;
         end
         pmfb_pkg::PH_90: begin
            mix_re = tw_im;
            mix_im = -tw_re;
         end
         pmfb_pkg::PH_180: begin
            mix_re = -tw_re;
            mix_im = -tw_im;
         end
         default: begin
            mix_re = -tw_im;
            mix_im = tw_re;
         end
      endcase
   end

   assign mix_prod_re = sample_s * mix_re;
   assign mix_prod_im = sample_s * mix_im;

   // Row read on acceptance. The row written back in this cycle belongs to another
   // channel, since there are at least two, so the read never needs forwarding.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_row_ff    <= delay_mem[ch_ff];
         s1_new_re_ff <= pmfb_pkg::PROD_W'(mix_prod_re);
         s1_new_im_ff <= pmfb_pkg::PROD_W'(mix_prod_im);
         s1_ch_ff     <= ch_ff;
         s1_last_ff   <= ch_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rd_ok_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
         if (req_fire) begin
            rd_ok_ff <= row_valid_ff[ch_ff];
         end
      end
   end

   // Shift the new product in at the newest end; a never-written row reads as zero.
   assign old_row    = rd_ok_ff ? rd_row_ff : '0;
   assign s1_ch_wide = 7'(s1_ch_ff);

   always_comb begin
      new_row.re[0] = s1_new_re_ff;
      new_row.im[0] = s1_new_im_ff;
      for (int k = 1; k < pmfb_pkg::TAPS; k++) begin
         new_row.re[k] = old_row.re[k-1];
         new_row.im[k] = old_row.im[k-1];
      end
   end

   // Tap products, coefficient k applied to the k-th newest entry.
   always_comb begin
      for (int k = 0; k < pmfb_pkg::TAPS; k++) begin
         mul_re_in[k] = $signed(new_row.re[k])
                      * pmfb_pkg::tap_coef(s1_ch_wide[pmfb_pkg::TBL_CH_W-1:0], k);
         mul_im_in[k] = $signed(new_row.im[k])
                      * pmfb_pkg::tap_coef(s1_ch_wide[pmfb_pkg::TBL_CH_W-1:0], k);
      end
   end

   // Write back the shifted row.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         delay_mem[s1_ch_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (s1_valid_ff) begin
         row_valid_ff[s1_ch_ff] <= 1'b1;
      end
   end

   // Stage 2 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mul_re_ff  <= mul_re_in;
         mul_im_ff  <= mul_im_in;
         s2_ch_ff   <= s1_ch_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Group sums over up to four taps each, modulo 2^32.
   always_comb begin
      for (int g = 0; g < pmfb_pkg::GROUPS; g++) begin
         grp_re_in[g] = '0;
         grp_im_in[g] = '0;
         for (int j = 0; j < pmfb_pkg::GROUP_SIZE; j++) begin
            if (g * pmfb_pkg::GROUP_SIZE + j < pmfb_pkg::TAPS) begin
               grp_re_in[g] = grp_re_in[g]
                  + pmfb_pkg::ACC_W'(mul_re_ff[g * pmfb_pkg::GROUP_SIZE + j]);
               grp_im_in[g] = grp_im_in[g]
                  + pmfb_pkg::ACC_W'(mul_im_ff[g * pmfb_pkg::GROUP_SIZE + j]);
            end
         end
      end
   end

   // Stage 3 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         grp_re_ff  <= grp_re_in;
         grp_im_ff  <= grp_im_in;
         s3_ch_ff   <= s2_ch_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // Final sum over the groups.
   assign s3_ch_wide = 7'(s3_ch_ff);

   always_comb begin
      push_data.re   = '0;
      push_data.im   = '0;
      for (int g = 0; g < pmfb_pkg::GROUPS; g++) begin
         push_data.re = push_data.re + grp_re_ff[g];
         push_data.im = push_data.im + grp_im_ff[g];
      end
      push_data.ch   = s3_ch_wide[pmfb_pkg::CH_OUT_W-1:0];
      push_data.last = s3_last_ff;
   end

   // Output queue.
   assign fifo_push = s3_valid_ff;
   assign fifo_pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (fifo_push && !fifo_pop) begin
         count_in = count_ff + (pmfb_pkg::FIFO_AW+1)'(1);
      end else if (!fifo_push && fifo_pop) begin
         count_in = count_ff - (pmfb_pkg::FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (fifo_push) begin
            wr_ptr_ff <= wr_ptr_ff + pmfb_pkg::FIFO_AW'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + pmfb_pkg::FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Result ports.
   assign head       = fifo_mem_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = pmfb_pkg::RSP_DATA_W'({head.im, head.re, head.ch});

   // The reserved room must keep the queue from ever overflowing.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (fifo_push && !fifo_pop) |-> (count_ff < (pmfb_pkg::FIFO_AW+1)'(pmfb_pkg::FIFO_DEPTH)))
      else $error("output queue overflow");

   // A write-back never hits the row being read in the same cycle.
   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && req_fire) |-> (s1_ch_ff != ch_ff))
      else $error("delay row read and write-back collide");

   // The last channel of a frame wraps the channel counter and advances the phase.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ch_last) |=>
         (ch_ff == '0 && phase_ff == pmfb_pkg::phase_type'($past(phase_ff) + 2'd1)))
      else $error("frame wrap failed");

   // An accepted request reaches the queue through the stage 1, 2 and 3 registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##3 fifo_push)
      else $error("request lost in pipeline");

endmodule
